[design/ffba_pkg.sv]
`timescale 1ns / 1ps

package ffba_pkg;

   // Table and block geometry.
   localparam int MAX_BLOCKS       = 64;
   localparam int DESCRIPTOR_BYTES = 16;
   // The rounding in the top level masks low bits, so the alignment must be a power of two.
   localparam int ALIGN_BYTES      = 16;

   localparam int ADDR_W      = 32;
   localparam int CSR_INDEX_W = 1;

   // Request kinds carried in tuser.
   typedef enum logic [0:0] {
      OP_ALLOCATE = 1'b0,
      OP_FREE     = 1'b1
   } opcode_type;

   // Completion codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_SPACE  = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEAP_TOP    = 1'b0,
      CSR_HEAP_BOTTOM = 1'b1
   } csr_index_type;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_APPLY,
      ST_RESP
   } state_type;

   // Action that one table cell takes in a cycle.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD_NEW,
      CELL_TAKE_ABOVE,
      CELL_TAKE_BELOW
   } cell_op_type;

   // One allocated block: descriptor base and the address just past its payload.
   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] block_end;
   } entry_type;

   // Request data broadcast to every cell.
   typedef struct packed {
      logic [ADDR_W-1:0] need;
      logic [ADDR_W-1:0] free_address;
      logic [ADDR_W-1:0] heap_bottom;
   } cell_cmd_type;

   // Per-cell search results.
   typedef struct packed {
      logic              fit;
      logic              match;
      logic [ADDR_W-1:0] cand;
   } cell_flags_type;

endpackage

[design/first_fit_block_allocator_top.sv]
`timescale 1ns / 1ps

// First-fit block allocator. An allocate request (tuser 0) rounds its size up to a multiple
// of 16 bytes, adds a 16-byte descriptor and places the block just below the upper edge of
// the first gap, searched from heap_top down to heap_bottom, that holds it; the response
// carries the payload address or a no-space status. A free request (tuser 1) removes the
// block whose payload address matches. The table is a row of MAX_BLOCKS cells sorted by
// descending base; every cell tests its own gap in parallel and an insertion or removal
// shifts the cells below that point by one cell in the table update step. A request passes
// through four steps (accept, gap test, table update, response register) and waits in the
// last while the response register is still full; one request is in flight at a time. Write
// heap_top and heap_bottom only while no request is outstanding.
module first_fit_block_allocator_top #(
   parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] request_bytes, [63:32] block_address
   input  logic [63:0] req_tdata,
   // [0] opcode
   input  logic [0:0]  req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] payload_address, [33:32] status, [39:34] zero
   output logic [39:0] rsp_tdata,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ffba_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0] csr_data
);
   import ffba_pkg::*;

   localparam int COUNT_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [ADDR_W+1:0] ALIGN_MASK = (ADDR_W+2)'(ALIGN_BYTES - 1);

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    heap_top_ff, heap_bottom_ff;
   logic [COUNT_W-1:0]   count_ff, count_in;
   opcode_type           opcode_ff;
   logic [ADDR_W-1:0]    need_ff;
   logic                 overflow_ff;
   logic [ADDR_W-1:0]    address_ff;
   logic [ADDR_W-1:0]    result_address_ff, result_address_in;
   status_type           result_status_ff, result_status_in;
   logic                 rsp_valid_ff;
   logic [ADDR_W-1:0]    rsp_address_ff;
   status_type           rsp_status_ff;

   logic                 req_accept;
   logic                 rsp_load;
   logic [ADDR_W+1:0]    rounded;
   logic [ADDR_W+1:0]    need_wide;

   cell_cmd_type         cmd;
   entry_type            entries [MAX_BLOCKS];
   cell_flags_type       flags [MAX_BLOCKS];
   cell_op_type          cell_ops [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] occupied, at_count;
   logic [MAX_BLOCKS-1:0] fit_vec, match_vec, fit_incl, match_incl, fit_first;
   logic [ADDR_W-1:0]    cand_sel;
   logic                 table_full, table_empty;
   logic                 alloc_ok, free_remove;

   // Handshakes.
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Size rounding and descriptor; a need beyond 32 bits can never fit.
   assign rounded   = ({2'b00, req_tdata[31:0]} + ALIGN_MASK) & ~ALIGN_MASK;
   assign need_wide = rounded + (ADDR_W+2)'(DESCRIPTOR_BYTES);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_top_ff    <= '0;
         heap_bottom_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEAP_TOP:    heap_top_ff    <= csr_data;
            CSR_HEAP_BOTTOM: heap_bottom_ff <= csr_data;
            default:         heap_top_ff    <= heap_top_ff;
         endcase
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         opcode_ff   <= opcode_type'(req_tuser[0]);
         need_ff     <= need_wide[ADDR_W-1:0];
         overflow_ff <= |need_wide[ADDR_W+1:ADDR_W];
         address_ff  <= req_tdata[63:32];
      end
   end

   assign cmd = '{need: need_ff, free_address: address_ff, heap_bottom: heap_bottom_ff};

   // Row of cells; a gap's upper edge is the cell above's base, or heap_top at cell 0.
   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      logic [ADDR_W-1:0] upper;
      entry_type         above, below;

      assign occupied[i]  = COUNT_W'(i) < count_ff;
      assign at_count[i]  = COUNT_W'(i) == count_ff;
      assign fit_vec[i]   = flags[i].fit;
      assign match_vec[i] = flags[i].match;

      if (i == 0) begin : g_first
         assign upper = heap_top_ff;
         assign above = entries[i];
      end else begin : g_inner
         assign upper = entries[i-1].base;
         assign above = entries[i-1];
      end

      if (i == MAX_BLOCKS - 1) begin : g_last
         assign below = entries[i];
      end else begin : g_not_last
         assign below = entries[i+1];
      end

      ffba_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .op          (cell_ops[i]),
         .occupied    (occupied[i]),
         .at_count    (at_count[i]),
         .upper_in    (upper),
         .above_entry (above),
         .below_entry (below),
         .entry       (entries[i]),
         .flags       (flags[i])
      );
   end

   // Prefix OR over the row in log steps, to find the first fitting gap and first match.
   always_comb begin
      fit_incl   = fit_vec;
      match_incl = match_vec;
      for (int s = 1; s < MAX_BLOCKS; s = s * 2) begin
         fit_incl   = fit_incl | (fit_incl << s);
         match_incl = match_incl | (match_incl << s);
      end
      fit_first = fit_vec & ~(fit_incl << 1);
   end

   // Candidate base of the chosen gap.
   always_comb begin
      cand_sel = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         cand_sel = cand_sel | (fit_first[i] ? flags[i].cand : '0);
      end
   end

   assign table_full  = count_ff == COUNT_W'(MAX_BLOCKS);
   assign table_empty = count_ff == '0;
   assign alloc_ok    = (opcode_ff == OP_ALLOCATE) && !table_full && !overflow_ff && (|fit_vec);
   assign free_remove = (opcode_ff == OP_FREE) && !table_empty && (address_ff != '0)
                        && (|match_vec);

   // Cell actions in the update cycle.
   always_comb begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         cell_ops[i] = CELL_HOLD;
         if (state_ff == ST_APPLY) begin
            priority if (alloc_ok && fit_first[i]) begin
               cell_ops[i] = CELL_LOAD_NEW;
            end else if (alloc_ok && (fit_incl[i] && (occupied[i] || at_count[i]))) begin
               cell_ops[i] = CELL_TAKE_ABOVE;
            end else if (free_remove && match_incl[i] && occupied[i]) begin
               cell_ops[i] = CELL_TAKE_BELOW;
            end else begin
               cell_ops[i] = CELL_HOLD;
            end
         end
      end
   end

   // Result and block count of the update cycle.
   always_comb begin
      result_address_in = result_address_ff;
      result_status_in  = result_status_ff;
      count_in          = count_ff;
      if (state_ff == ST_APPLY) begin
         result_address_in = '0;
         if (opcode_ff == OP_ALLOCATE) begin
            if (alloc_ok) begin
               result_address_in = cand_sel + ADDR_W'(DESCRIPTOR_BYTES);
               result_status_in  = STATUS_OK;
               count_in          = count_ff + COUNT_W'(1);
            end else begin
               result_status_in  = STATUS_NO_SPACE;
            end
         end else begin
            priority if (table_empty) begin
               result_status_in = STATUS_NOT_FOUND;
            end else if (address_ff == '0) begin
               result_status_in = STATUS_OK;
            end else if (free_remove) begin
               result_status_in = STATUS_OK;
               count_in         = count_ff - COUNT_W'(1);
            end else begin
               result_status_in = STATUS_NOT_FOUND;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      result_address_ff <= result_address_in;
      result_status_ff  <= result_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_accept) state_in = ST_EVAL;
         ST_EVAL:  state_in = ST_APPLY;
         ST_APPLY: state_in = ST_RESP;
         ST_RESP:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_RESP:  rsp_load   = !rsp_valid_ff || rsp_tready;
         default:  req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_address_ff <= result_address_ff;
         rsp_status_ff  <= result_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_status_ff, rsp_address_ff};

endmodule

[design/ffba_cell.sv]
`timescale 1ns / 1ps

module ffba_cell (
   input  logic                   clock,
   input  ffba_pkg::cell_cmd_type cmd,
   input  ffba_pkg::cell_op_type  op,
   input  logic                   occupied,
   input  logic                   at_count,
   input  logic [31:0]            upper_in,
   input  ffba_pkg::entry_type    above_entry,
   input  ffba_pkg::entry_type    below_entry,
   output ffba_pkg::entry_type    entry,
   output ffba_pkg::cell_flags_type flags
);
   import ffba_pkg::*;

   entry_type         entry_ff;
   entry_type         entry_in;
   cell_flags_type    flags_ff;
   cell_flags_type    flags_in;
   logic [ADDR_W-1:0] upper_ff;
   logic [ADDR_W-1:0] lower;
   logic [ADDR_W-1:0] gap;
   logic [ADDR_W-1:0] payload;

   // Gap test: the gap below the neighbor above, down to this block or to the heap bottom.
   always_comb begin
      lower          = occupied ? entry_ff.block_end : cmd.heap_bottom;
      gap            = upper_in - lower;
      payload        = entry_ff.base + ADDR_W'(DESCRIPTOR_BYTES);
      flags_in.fit   = (occupied || at_count) && (upper_in >= lower) && (gap >= cmd.need);
      flags_in.match = occupied && (payload == cmd.free_address);
      flags_in.cand  = upper_in - cmd.need;
   end

   // Table update: keep, load the new block, or shift from a neighbor.
   always_comb begin
      unique case (op)
         CELL_HOLD:       entry_in = entry_ff;
         CELL_LOAD_NEW:   entry_in = '{base: flags_ff.cand, block_end: upper_ff};
         CELL_TAKE_ABOVE: entry_in = above_entry;
         CELL_TAKE_BELOW: entry_in = below_entry;
         default:         entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      flags_ff <= flags_in;
      upper_ff <= upper_in;
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule
